/* rtl/sswt_pkg.sv */
// shared types, constants and helpers for the scale stability weigher
package sswt_pkg;

    localparam int unsigned SAMPLE_W   = 24;
    localparam int unsigned WINDOW_W   = 16;
    localparam int unsigned SETTLE_W   = 4;
    localparam int unsigned WEIGHT_W   = 21;
    localparam int unsigned OFFSET_W   = 32;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam int unsigned COUNTS_PER_UNIT = 10;
    localparam int unsigned UNIT_STEP       = 1;

    // rounded divide by counts per unit: multiply by scaled reciprocal, then shift
    localparam int unsigned NUM_W     = SAMPLE_W + 1;
    localparam int unsigned DIV_SHIFT = 35;
    localparam int unsigned PROD_W    = DIV_SHIFT + NUM_W;
    localparam longint unsigned DIV_MUL =
        ((64'd1 << DIV_SHIFT) + COUNTS_PER_UNIT - 1) / COUNTS_PER_UNIT;
    localparam int unsigned ROUND_HALF = COUNTS_PER_UNIT / 2;
    localparam int unsigned WEIGHT_MAX = (1 << WEIGHT_W) - 1;

    localparam logic [WINDOW_W-1:0]   RST_STABLE_WINDOW   = 16'd3;
    localparam logic [WINDOW_W-1:0]   RST_UNSTABLE_WINDOW = 16'd50;
    localparam logic [SETTLE_W-1:0]   RST_SETTLE_SAMPLES  = 4'd5;
    localparam logic [SAMPLE_W-1:0]   RST_EMPTY_REF       = 24'd0;
    localparam logic [SAMPLE_W-1:0]   RST_TARE_REF        = 24'd0;
    localparam logic [OFFSET_W-1:0]   RST_ZERO_BIAS       = 32'd20000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STABLE_WINDOW   = 3'd0,
        CFG_UNSTABLE_WINDOW = 3'd1,
        CFG_SETTLE_SAMPLES  = 3'd2,
        CFG_EMPTY_REF       = 3'd3,
        CFG_TARE_REF        = 3'd4,
        CFG_ZERO_BIAS       = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [WINDOW_W-1:0] stable_window;
        logic [WINDOW_W-1:0] unstable_window;
        logic [SETTLE_W-1:0] settle_samples;
        logic [SAMPLE_W-1:0] empty_ref;
        logic [SAMPLE_W-1:0] tare_ref;
        logic [OFFSET_W-1:0] zero_bias;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                refresh_request;
    } t_in_item;

    typedef struct packed {
        logic                stable;
        logic                negative;
        logic [WEIGHT_W-1:0] weight;
        logic [SAMPLE_W-1:0] display_value;
        logic [OFFSET_W-1:0] offset_tare_value;
        logic [OFFSET_W-1:0] offset_true_value;
    } t_out_item;

    // inclusive window test: |value - centre| <= half
    function automatic logic win_hit(
        input logic [SAMPLE_W-1:0] value,
        input logic [SAMPLE_W-1:0] centre,
        input logic [WINDOW_W-1:0] half
    );
        logic [SAMPLE_W-1:0] gap;
        if (value >= centre) begin
            gap = value - centre;
        end else begin
            gap = centre - value;
        end
        return gap <= SAMPLE_W'(half);
    endfunction

endpackage

/* rtl/sswt_judge.sv */
// stability judge: stable flag, settle counter and held display sample
module sswt_judge (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_advance,
    input  sswt_pkg::t_in_item                i_item,
    input  sswt_pkg::t_cfg                    i_cfg,
    output logic                              o_stable,
    output logic [sswt_pkg::SAMPLE_W-1:0]     o_shown
);

    logic                            r_stable;
    logic [sswt_pkg::SETTLE_W-1:0]   r_count;
    logic [sswt_pkg::SAMPLE_W-1:0]   r_shown;

    logic                            n_stable;
    logic [sswt_pkg::SETTLE_W-1:0]   n_count;
    logic [sswt_pkg::SAMPLE_W-1:0]   n_shown;

    logic                            w_leave;
    logic                            w_stable_mid;
    logic [sswt_pkg::SETTLE_W-1:0]   w_count_mid;
    logic                            w_refresh;

    always_comb begin
        w_leave = r_stable &&
                  !sswt_pkg::win_hit(i_item.sample, r_shown, i_cfg.unstable_window);
        w_stable_mid = r_stable && !w_leave;
        w_count_mid  = w_leave ? i_cfg.settle_samples : r_count;
        w_refresh    = i_item.refresh_request || w_leave;
        n_stable     = w_stable_mid;
        n_count      = w_count_mid;
        if (w_stable_mid) begin
            n_count = i_cfg.settle_samples;
        end else if (!sswt_pkg::win_hit(i_item.sample, r_shown, i_cfg.stable_window)) begin
            n_count   = i_cfg.settle_samples;
            w_refresh = 1'b1;
        end else if (w_count_mid <= sswt_pkg::SETTLE_W'(1)) begin
            n_count   = '0;
            n_stable  = 1'b1;
            w_refresh = 1'b1;
        end else begin
            n_count = w_count_mid - sswt_pkg::SETTLE_W'(1);
        end
        n_shown = w_refresh ? i_item.sample : r_shown;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b0;
            r_count  <= sswt_pkg::RST_SETTLE_SAMPLES;
            r_shown  <= '0;
        end else if (i_advance) begin
            r_stable <= n_stable;
            r_count  <= n_count;
            r_shown  <= n_shown;
        end
    end

    assign o_stable = n_stable;
    assign o_shown  = n_shown;

endmodule

/* rtl/sswt_weigh.sv */
// weight former: tare-relative magnitude in units and biased offsets
module sswt_weigh (
    input  logic [sswt_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [sswt_pkg::SAMPLE_W-1:0]  i_shown,
    input  sswt_pkg::t_cfg                 i_cfg,
    output logic                           o_negative,
    output logic [sswt_pkg::WEIGHT_W-1:0]  o_weight,
    output logic [sswt_pkg::OFFSET_W-1:0]  o_ofs_tare,
    output logic [sswt_pkg::OFFSET_W-1:0]  o_ofs_true
);

    logic [sswt_pkg::SAMPLE_W-1:0]  w_diff;
    logic [sswt_pkg::NUM_W-1:0]     w_num;
    logic [sswt_pkg::PROD_W-1:0]    w_prod;
    logic [sswt_pkg::NUM_W-1:0]     w_quot;
    logic [sswt_pkg::OFFSET_W-1:0]  w_scaled;

    always_comb begin
        o_negative = i_shown < i_cfg.tare_ref;
        w_diff     = o_negative ? (i_cfg.tare_ref - i_shown) : (i_shown - i_cfg.tare_ref);
        w_num      = sswt_pkg::NUM_W'(w_diff) + sswt_pkg::NUM_W'(sswt_pkg::ROUND_HALF);
        w_prod     = sswt_pkg::PROD_W'(w_num) * sswt_pkg::PROD_W'(sswt_pkg::DIV_MUL);
        w_quot     = w_prod[sswt_pkg::DIV_SHIFT +: sswt_pkg::NUM_W];
        w_scaled   = sswt_pkg::OFFSET_W'(w_quot) * sswt_pkg::OFFSET_W'(sswt_pkg::UNIT_STEP);
        if (w_scaled > sswt_pkg::OFFSET_W'(sswt_pkg::WEIGHT_MAX)) begin
            o_weight = sswt_pkg::WEIGHT_W'(sswt_pkg::WEIGHT_MAX);
        end else begin
            o_weight = w_scaled[sswt_pkg::WEIGHT_W-1:0];
        end
        o_ofs_tare = sswt_pkg::OFFSET_W'(i_sample) - sswt_pkg::OFFSET_W'(i_cfg.tare_ref)
                     + i_cfg.zero_bias;
        o_ofs_true = o_ofs_tare + sswt_pkg::OFFSET_W'(i_cfg.tare_ref)
                     - sswt_pkg::OFFSET_W'(i_cfg.empty_ref);
    end

endmodule

/* rtl/scale_stability_weigher_core.sv */
// top level of the scale stability weigher: registers, handshake and assertions
// One item per clock cycle sustained while output is not stalled. After its item is
// accepted, the result is offered from the result register: an item sits in the input
// register, passes the stability judge and weight former in one combinational pass and
// lands in the result register. The stable flag, settle counter and display sample
// update on the same edge as the result register, so consecutive items see each
// other's state with no gap. A result held by output stall blocks the input register
// only, so one further item is still taken. Configuration writes are registered; the
// rounded weight uses a 25 by 32 bit reciprocal multiply.
module scale_stability_weigher_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  sswt_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output sswt_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic [sswt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sswt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    sswt_pkg::t_cfg       r_cfg;
    logic                 r_in_valid;
    sswt_pkg::t_in_item   r_in_item;
    logic                 r_out_valid;
    sswt_pkg::t_out_item  r_out_item;

    logic                            w_advance;
    logic                            w_stable;
    logic [sswt_pkg::SAMPLE_W-1:0]   w_shown;
    logic                            w_negative;
    logic [sswt_pkg::WEIGHT_W-1:0]   w_weight;
    logic [sswt_pkg::OFFSET_W-1:0]   w_ofs_tare;
    logic [sswt_pkg::OFFSET_W-1:0]   w_ofs_true;
    sswt_pkg::t_out_item             n_out_item;

    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stable_window   <= sswt_pkg::RST_STABLE_WINDOW;
            r_cfg.unstable_window <= sswt_pkg::RST_UNSTABLE_WINDOW;
            r_cfg.settle_samples  <= sswt_pkg::RST_SETTLE_SAMPLES;
            r_cfg.empty_ref       <= sswt_pkg::RST_EMPTY_REF;
            r_cfg.tare_ref        <= sswt_pkg::RST_TARE_REF;
            r_cfg.zero_bias       <= sswt_pkg::RST_ZERO_BIAS;
        end else if (i_cfg_we) begin
            unique case (sswt_pkg::t_cfg_index'(i_cfg_index))
                sswt_pkg::CFG_STABLE_WINDOW: begin
                    r_cfg.stable_window <= i_cfg_data[sswt_pkg::WINDOW_W-1:0];
                end
                sswt_pkg::CFG_UNSTABLE_WINDOW: begin
                    r_cfg.unstable_window <= i_cfg_data[sswt_pkg::WINDOW_W-1:0];
                end
                sswt_pkg::CFG_SETTLE_SAMPLES: begin
                    r_cfg.settle_samples <= i_cfg_data[sswt_pkg::SETTLE_W-1:0];
                end
                sswt_pkg::CFG_EMPTY_REF: begin
                    r_cfg.empty_ref <= i_cfg_data[sswt_pkg::SAMPLE_W-1:0];
                end
                sswt_pkg::CFG_TARE_REF: begin
                    r_cfg.tare_ref <= i_cfg_data[sswt_pkg::SAMPLE_W-1:0];
                end
                sswt_pkg::CFG_ZERO_BIAS: begin
                    r_cfg.zero_bias <= i_cfg_data[sswt_pkg::OFFSET_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    sswt_judge u_judge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (r_in_item),
        .i_cfg     (r_cfg),
        .o_stable  (w_stable),
        .o_shown   (w_shown)
    );

    sswt_weigh u_weigh (
        .i_sample   (r_in_item.sample),
        .i_shown    (w_shown),
        .i_cfg      (r_cfg),
        .o_negative (w_negative),
        .o_weight   (w_weight),
        .o_ofs_tare (w_ofs_tare),
        .o_ofs_true (w_ofs_true)
    );

    always_comb begin
        n_out_item.stable            = w_stable;
        n_out_item.negative          = w_negative;
        n_out_item.weight            = w_weight;
        n_out_item.display_value     = w_shown;
        n_out_item.offset_tare_value = w_ofs_tare;
        n_out_item.offset_true_value = w_ofs_true;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // stall only when both registers hold an item and the result is held back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("advanced item did not reach the result register");

    // a pending result agrees with the judge state it was formed from
    a_display_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_item.display_value == u_judge.r_shown))
        else $error("held display sample differs from pending result");

endmodule
